>>> design/cdwt_pkg.sv
// ----------------------------------------------------------------------------
// cdwt_pkg
// Shared types, constants and codes of the command driven watchdog timer.
// ----------------------------------------------------------------------------
`default_nettype none

package cdwt_pkg;

  // Timing constants in ticks, reboot press count and fired count limit
  localparam logic [15:0] TIMEOUT_MIN    = 16'd50;
  localparam logic [15:0] TIMEOUT_MAX    = 16'd3000;
  localparam logic [15:0] TIMEOUT_STEP   = 16'd50;
  localparam logic [3:0]  REBOOT_PRESSES = 4'd5;
  localparam logic [15:0] IDLE_TICKS     = 16'd36000;
  localparam logic [15:0] FIRED_MAX      = 16'hFFFF;

  // Register reset values
  localparam logic [15:0] RST_TIMEOUT = 16'd300;

  // Configuration register indexes
  localparam logic [2:0] CFG_PERM       = 3'd0;
  localparam logic [2:0] CFG_LOCK       = 3'd1;
  localparam logic [2:0] CFG_INIT_TMO   = 3'd2;
  localparam logic [2:0] CFG_INIT_MODE  = 3'd3;
  localparam logic [2:0] CFG_INIT_FIRED = 3'd4;
  localparam logic [2:0] CFG_FACT_TMO   = 3'd5;
  localparam logic [2:0] CFG_FACT_MODE  = 3'd6;

  // Request kinds
  localparam logic REQ_TICK = 1'b0;

  // Reply codes
  localparam logic [2:0] RC_TICK    = 3'd0;
  localparam logic [2:0] RC_ACK     = 3'd1;
  localparam logic [2:0] RC_REFUSED = 3'd2;
  localparam logic [2:0] RC_UNKNOWN = 3'd3;
  localparam logic [2:0] RC_STATUS  = 3'd4;
  localparam logic [2:0] RC_CONFIG  = 3'd5;
  localparam logic [2:0] RC_VERSION = 3'd6;
  localparam logic [2:0] RC_RLIST   = 3'd7;

  // Permission mask bits
  localparam int PERM_DEBUG  = 0;
  localparam int PERM_REBOOT = 1;
  localparam int PERM_TMO    = 2;
  localparam int PERM_MODE   = 3;
  localparam int PERM_CLEAR  = 4;

  // Command characters
  localparam logic [7:0] CMD_RESET   = 8'h46; // F
  localparam logic [7:0] CMD_POWER   = 8'h50; // P
  localparam logic [7:0] CMD_REBOOT  = 8'h23; // #
  localparam logic [7:0] CMD_LINK    = 8'h21; // !
  localparam logic [7:0] CMD_FACTORY = 8'h3C; // <
  localparam logic [7:0] CMD_NOP     = 8'h3E; // >
  localparam logic [7:0] CMD_SHORTEN = 8'h2A; // *
  localparam logic [7:0] CMD_DISARM  = 8'h78; // x
  localparam logic [7:0] CMD_ARM     = 8'h58; // X
  localparam logic [7:0] CMD_RELOAD  = 8'h52; // R
  localparam logic [7:0] CMD_CLEAR   = 8'h30; // 0
  localparam logic [7:0] CMD_MODE0   = 8'h6D; // m
  localparam logic [7:0] CMD_MODE1   = 8'h4D; // M
  localparam logic [7:0] CMD_TMO_DN  = 8'h2D; // -
  localparam logic [7:0] CMD_TMO_UP  = 8'h2B; // +
  localparam logic [7:0] CMD_CONFIG  = 8'h43; // C
  localparam logic [7:0] CMD_STATUS  = 8'h53; // S
  localparam logic [7:0] CMD_VERSION = 8'h56; // V
  localparam logic [7:0] CMD_RLIST   = 8'h51; // Q

  typedef struct packed {
    logic [4:0]  perm;
    logic        lock_disarm;
    logic [15:0] init_timeout;
    logic        init_mode;
    logic [15:0] init_fired;
    logic [15:0] fact_timeout;
    logic        fact_mode;
  } cdwt_cfg_t;

  typedef struct packed {
    logic        armed;
    logic        fired;
    logic [15:0] countdown;
    logic [15:0] timeout;
    logic        mode;
    logic [15:0] fired_count;
    logic [3:0]  presses;
    logic [15:0] idle_count;
  } cdwt_state_t;

  typedef struct packed {
    logic [2:0] reply_code;
    logic       reset_pulse;
    logic       power_pulse;
    logic       self_reboot;
    logic       link_reinit;
  } cdwt_event_t;

endpackage

`default_nettype wire

>>> design/cdwt_step.sv
// ----------------------------------------------------------------------------
// cdwt_step
// Next-state and event decode for one tick or one command byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cdwt_step (
  input  wire cdwt_pkg::cdwt_cfg_t   cfg,
  input  wire cdwt_pkg::cdwt_state_t cur,
  input  wire                        req_type,
  input  wire [7:0]                  cmd_byte,
  output cdwt_pkg::cdwt_state_t      nxt,
  output cdwt_pkg::cdwt_event_t      evt
);
  import cdwt_pkg::*;

  logic               restart;
  logic [15:0]        idle_dec;
  logic signed [17:0] tmo_sum;
  logic [15:0]        tmo_step;

  // Stepped timeout, clamped to the allowed window
  always_comb begin
    if (cmd_byte == CMD_TMO_UP) begin
      tmo_sum = $signed({2'b00, cur.timeout}) + $signed({2'b00, TIMEOUT_STEP});
    end else begin
      tmo_sum = $signed({2'b00, cur.timeout}) - $signed({2'b00, TIMEOUT_STEP});
    end
    tmo_step = tmo_sum[15:0];
    if (tmo_sum < $signed({2'b00, TIMEOUT_MIN})) begin
      tmo_step = TIMEOUT_MIN;
    end
    if (tmo_sum >= $signed({2'b00, TIMEOUT_MAX})) begin
      tmo_step = TIMEOUT_MAX;
    end
  end

  assign idle_dec = cur.idle_count - 16'd1;

  // Decode the request and update state
  always_comb begin
    nxt     = cur;
    evt     = '0;
    restart = 1'b0;
    if (req_type == REQ_TICK) begin
      evt.reply_code = RC_TICK;
      nxt.idle_count = idle_dec;
      if (cur.armed) begin
        if (cur.countdown == 16'd0) begin
          evt.power_pulse = cur.mode;
          evt.reset_pulse = ~cur.mode;
          nxt.armed       = 1'b0;
          nxt.fired       = 1'b1;
          if (cur.fired_count != FIRED_MAX) begin
            nxt.fired_count = cur.fired_count + 16'd1;
          end
        end else begin
          nxt.countdown = cur.countdown - 16'd1;
        end
      end
      if (idle_dec == 16'd0) begin
        restart         = 1'b1;
        evt.link_reinit = 1'b1;
      end
    end else begin
      if (cmd_byte != CMD_REBOOT) begin
        nxt.presses = REBOOT_PRESSES;
      end
      nxt.idle_count = IDLE_TICKS;
      evt.reply_code = RC_ACK;
      case (cmd_byte)
        CMD_RESET: begin
          if (cfg.perm[PERM_DEBUG]) evt.reset_pulse = 1'b1;
          else evt.reply_code = RC_REFUSED;
        end
        CMD_POWER: begin
          if (cfg.perm[PERM_DEBUG]) evt.power_pulse = 1'b1;
          else evt.reply_code = RC_REFUSED;
        end
        CMD_REBOOT: begin
          if (!cfg.perm[PERM_REBOOT]) begin
            evt.reply_code = RC_REFUSED;
          end else if (cur.presses <= 4'd1) begin
            restart         = 1'b1;
            evt.self_reboot = 1'b1;
            evt.link_reinit = 1'b1;
          end else begin
            nxt.presses = cur.presses - 4'd1;
          end
        end
        CMD_LINK: begin
          evt.link_reinit = 1'b1;
        end
        CMD_FACTORY: begin
          nxt.timeout = cfg.fact_timeout;
          nxt.mode    = cfg.fact_mode;
          if (cfg.perm[PERM_CLEAR]) nxt.fired_count = '0;
          if (cur.armed) nxt.countdown = cfg.fact_timeout;
        end
        CMD_NOP: begin
          evt.reply_code = RC_ACK;
        end
        CMD_SHORTEN: begin
          if (cur.armed) nxt.countdown = TIMEOUT_MIN;
          evt.reply_code = RC_STATUS;
        end
        CMD_DISARM: begin
          if (cfg.lock_disarm) begin
            evt.reply_code = RC_REFUSED;
          end else begin
            if (cur.armed) nxt.countdown = cur.timeout;
            nxt.armed      = 1'b0;
            evt.reply_code = RC_STATUS;
          end
        end
        CMD_ARM: begin
          nxt.armed      = 1'b1;
          nxt.countdown  = cur.timeout;
          nxt.fired      = 1'b0;
          evt.reply_code = RC_STATUS;
        end
        CMD_RELOAD: begin
          if (cur.armed) nxt.countdown = cur.timeout;
        end
        CMD_CLEAR: begin
          if (cfg.perm[PERM_CLEAR]) nxt.fired_count = '0;
          else evt.reply_code = RC_REFUSED;
        end
        CMD_MODE0, CMD_MODE1: begin
          if (cfg.perm[PERM_MODE]) nxt.mode = (cmd_byte == CMD_MODE1);
          else evt.reply_code = RC_REFUSED;
        end
        CMD_TMO_DN, CMD_TMO_UP: begin
          if (cfg.perm[PERM_TMO]) begin
            nxt.timeout = tmo_step;
            if (cur.armed) nxt.countdown = tmo_step;
          end else begin
            evt.reply_code = RC_REFUSED;
          end
        end
        CMD_CONFIG:  evt.reply_code = RC_CONFIG;
        CMD_STATUS:  evt.reply_code = RC_STATUS;
        CMD_VERSION: evt.reply_code = RC_VERSION;
        CMD_RLIST:   evt.reply_code = RC_RLIST;
        default:     evt.reply_code = RC_UNKNOWN;
      endcase
    end

    // Restart: reload everything but the fired count
    if (restart) begin
      nxt.armed      = 1'b0;
      nxt.fired      = 1'b0;
      nxt.timeout    = cfg.init_timeout;
      nxt.countdown  = cfg.init_timeout;
      nxt.mode       = cfg.init_mode;
      nxt.presses    = REBOOT_PRESSES;
      nxt.idle_count = IDLE_TICKS;
    end
  end

endmodule

`default_nettype wire

>>> design/command_driven_watchdog_timer_core.sv
// The result word of an accepted word is on out_ in the cycle after it is accepted.
// Throughput: one word per cycle while out_tready is high; the whole update is one pass of decode
// logic between the state registers and the result register.
// in_tready drops only while a result is held and out_tready is low.
// Reset (rst_n low, synchronous) restores configuration registers and
// watchdog state to their reset values and empties the result register.
// ----------------------------------------------------------------------------
// command_driven_watchdog_timer_core
// Watchdog timer driven by tick and command words, with a write-only
// configuration port and one result word per accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

module command_driven_watchdog_timer_core (
  input  wire        clk,
  input  wire        rst_n,
  // configuration
  input  wire        cfg_we,
  input  wire [2:0]  cfg_addr,
  input  wire [15:0] cfg_wdata,
  // request stream
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [7:0]  in_tdata,   // [7:0] cmd_byte
  input  wire        in_tuser,   // [0] req_type
  // result stream
  output logic       out_tvalid,
  input  wire        out_tready,
  // [0] reset_pulse, [1] power_pulse, [2] self_reboot, [3] link_reinit,
  // [4] is_armed, [5] has_fired, [21:6] countdown_now, [37:22] timeout_now,
  // [38] mode_now, [54:39] fired_total, [58:55] presses_left, [63:59] zero
  output logic [63:0] out_tdata,
  output logic [2:0]  out_tuser  // [2:0] reply_code
);
  import cdwt_pkg::*;

  cdwt_cfg_t   cfg_r;
  cdwt_state_t st_r;
  cdwt_state_t st_nxt;
  cdwt_event_t evt;
  cdwt_event_t evt_r;
  logic        out_valid_r;
  logic        in_fire;

  assign in_tready = ~out_valid_r | out_tready;
  assign in_fire   = in_tvalid & in_tready;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.perm         <= '0;
      cfg_r.lock_disarm  <= 1'b0;
      cfg_r.init_timeout <= RST_TIMEOUT;
      cfg_r.init_mode    <= 1'b0;
      cfg_r.init_fired   <= '0;
      cfg_r.fact_timeout <= RST_TIMEOUT;
      cfg_r.fact_mode    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PERM:       cfg_r.perm         <= cfg_wdata[4:0];
        CFG_LOCK:       cfg_r.lock_disarm  <= cfg_wdata[0];
        CFG_INIT_TMO:   cfg_r.init_timeout <= cfg_wdata;
        CFG_INIT_MODE:  cfg_r.init_mode    <= cfg_wdata[0];
        CFG_INIT_FIRED: cfg_r.init_fired   <= cfg_wdata;
        CFG_FACT_TMO:   cfg_r.fact_timeout <= cfg_wdata;
        CFG_FACT_MODE:  cfg_r.fact_mode    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  cdwt_step u_step (
    .cfg      (cfg_r),
    .cur      (st_r),
    .req_type (in_tuser),
    .cmd_byte (in_tdata),
    .nxt      (st_nxt),
    .evt      (evt)
  );

  // Advance watchdog state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.armed       <= 1'b0;
      st_r.fired       <= 1'b0;
      st_r.countdown   <= RST_TIMEOUT;
      st_r.timeout     <= RST_TIMEOUT;
      st_r.mode        <= 1'b0;
      st_r.fired_count <= '0;
      st_r.presses     <= REBOOT_PRESSES;
      st_r.idle_count  <= IDLE_TICKS;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold event flags with the result word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      evt_r <= evt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = evt_r.reply_code;
  assign out_tdata  = {5'd0, st_r.presses, st_r.fired_count, st_r.mode,
                       st_r.timeout, st_r.countdown, st_r.fired, st_r.armed,
                       evt_r.link_reinit, evt_r.self_reboot, evt_r.power_pulse,
                       evt_r.reset_pulse};

  // Checks on the decode and state
  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(evt_r.reset_pulse && evt_r.power_pulse))
    else $error("reset and power pulse in one word");

  a_self_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && evt_r.self_reboot |-> evt_r.link_reinit && !st_r.armed)
    else $error("self reboot without restart");

  a_presses_rng: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.presses != 4'd0 && st_r.presses <= REBOOT_PRESSES)
    else $error("reboot press counter out of range");

  a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted word produced no result");

endmodule

`default_nettype wire
